// ----- design/positional_array_table_assert.svh -----
// Assertion macros shared by the positional array table.
// Each macro uses the clock and reset of the module that includes it.
`ifndef POSITIONAL_ARRAY_TABLE_ASSERT_SVH
`define POSITIONAL_ARRAY_TABLE_ASSERT_SVH

`ifndef SYNTH
`define PAT_ASSERT_SAME(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("positional_array_table: same-cycle check failed");
`else
`define PAT_ASSERT_SAME(label, ante, cons)
`endif

`ifndef SYNTH
`define PAT_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("positional_array_table: next-cycle check failed");
`else
`define PAT_ASSERT_NEXT(label, ante, cons)
`endif

`endif

// ----- design/pat_pkg.sv -----
`timescale 1ns / 1ps

package pat_pkg;

   localparam logic [2:0] CMD_CLEAR  = 3'd0;
   localparam logic [2:0] CMD_APPEND = 3'd1;
   localparam logic [2:0] CMD_INSERT = 3'd2;
   localparam logic [2:0] CMD_DELETE = 3'd3;
   localparam logic [2:0] CMD_SEARCH = 3'd4;
   localparam logic [2:0] CMD_READ   = 3'd5;

   localparam logic [2:0] ST_OK       = 3'd0;
   localparam logic [2:0] ST_FULL     = 3'd1;
   localparam logic [2:0] ST_EMPTY    = 3'd2;
   localparam logic [2:0] ST_BADPOS   = 3'd3;
   localparam logic [2:0] ST_NOTFOUND = 3'd4;

   typedef struct packed {
      logic [2:0]         command;
      logic signed [31:0] value;
      logic [6:0]         position;
   } req_type;

   typedef struct packed {
      logic [2:0]         status;
      logic [6:0]         found_position;
      logic signed [31:0] data;
      logic [6:0]         count;
   } rsp_type;

endpackage

// ----- design/positional_array_table.sv -----
`timescale 1ns / 1ps
// Ordered table of signed 32-bit values with an entry count.
// Requests arrive on req_valid/req_stall/req_payload; each request carries a
// command, a value and a 1-based position. Every request gives exactly one
// result on rsp_valid/rsp_stall/rsp_payload with a status, a search position,
// read data and the entry count after the command.
// One request is worked on at a time; req_stall is high while it is in work.
// Clear, append, rejected commands and unknown commands go straight to the
// done state; read first waits for the registered table memory read.
// Insert and delete move one entry per step, a read and then a write of the
// table memory, and search reads and compares one entry per step.
// The output register lets a new request be accepted while a result waits.
// If the receiver stalls, the result holds in the output register, and a
// following finished result waits in the controller until the register frees.
// Reset empties the table and drops any pending result.

`include "positional_array_table_assert.svh"

module positional_array_table #(
   parameter int DEPTH = 64
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  pat_pkg::req_type  req_payload,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output pat_pkg::rsp_type  rsp_payload
);

   localparam int AW = $clog2(DEPTH);

   logic                 ready;
   logic                 req_fire;
   logic                 res_valid;
   logic                 res_take;
   pat_pkg::rsp_type     res;
   logic                 wr_en;
   logic [AW-1:0]        wr_addr;
   logic signed [31:0]   wr_data;
   logic                 rd_en;
   logic [AW-1:0]        rd_addr;
   logic signed [31:0]   rd_data;

   logic                 rsp_valid_ff;
   pat_pkg::rsp_type     rsp_payload_ff;
   logic                 rsp_ok;

   assign req_stall = !ready;
   assign req_fire  = req_valid && ready;
   assign res_take  = res_valid && (!rsp_valid_ff || !rsp_stall);

   pat_ctrl #(
      .DEPTH(DEPTH)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_fire  (req_fire),
      .req       (req_payload),
      .ready     (ready),
      .res_valid (res_valid),
      .res_take  (res_take),
      .res       (res),
      .wr_en     (wr_en),
      .wr_addr   (wr_addr),
      .wr_data   (wr_data),
      .rd_en     (rd_en),
      .rd_addr   (rd_addr),
      .rd_data   (rd_data)
   );

   pat_ram #(
      .DEPTH(DEPTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (res_take) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
      if (res_take) begin
         rsp_payload_ff <= res;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;
   assign rsp_ok      = (rsp_payload.status == pat_pkg::ST_OK);

   `PAT_ASSERT_NEXT(a_busy_after_accept, req_valid && !req_stall, req_stall)
   `PAT_ASSERT_NEXT(a_result_lands, res_take, rsp_valid)
   `PAT_ASSERT_SAME(a_found_only_ok, rsp_valid && rsp_payload.found_position != '0, rsp_ok)
   `PAT_ASSERT_SAME(a_data_only_ok, rsp_valid && rsp_payload.data != '0, rsp_ok)

endmodule

// ----- design/pat_ram.sv -----
`timescale 1ns / 1ps

module pat_ram #(
   parameter int DEPTH = 64
) (
   input  logic                       clock,
   input  logic                       wr_en,
   input  logic [$clog2(DEPTH)-1:0]   wr_addr,
   input  logic signed [31:0]         wr_data,
   input  logic                       rd_en,
   input  logic [$clog2(DEPTH)-1:0]   rd_addr,
   output logic signed [31:0]         rd_data
);

   logic signed [31:0] mem [DEPTH];
   logic signed [31:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- design/pat_ctrl.sv -----
`timescale 1ns / 1ps

module pat_ctrl #(
   parameter int DEPTH = 64
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_fire,
   input  pat_pkg::req_type           req,
   output logic                       ready,
   output logic                       res_valid,
   input  logic                       res_take,
   output pat_pkg::rsp_type           res,
   output logic                       wr_en,
   output logic [$clog2(DEPTH)-1:0]   wr_addr,
   output logic signed [31:0]         wr_data,
   output logic                       rd_en,
   output logic [$clog2(DEPTH)-1:0]   rd_addr,
   input  logic signed [31:0]         rd_data
);

   localparam int AW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);
   localparam int XW = ((CW > 7) ? CW : 7) + 1;

   typedef enum logic [3:0] {
      S_IDLE,
      S_UP,
      S_UP_WR,
      S_DN,
      S_DN_WR,
      S_SRCH,
      S_SCMP,
      S_RD_WAIT,
      S_DONE
   } state_type;

   state_type          state_ff, state_in;
   logic [CW-1:0]      idx_ff, idx_in;
   logic [CW-1:0]      tgt_ff, tgt_in;
   logic [CW-1:0]      cnt_ff, cnt_in;
   logic signed [31:0] val_ff, val_in;
   logic [2:0]         status_ff, status_in;
   logic [6:0]         fpos_ff, fpos_in;
   logic signed [31:0] data_ff, data_in;

   logic [CW-1:0]      idx_inc;
   logic [CW-1:0]      idx_dec;
   logic [XW-1:0]      pos_x;
   logic [XW-1:0]      cnt_x;
   logic [XW-1:0]      pos_m1;
   logic               full;
   logic               empty;

   assign idx_inc = idx_ff + CW'(1);
   assign idx_dec = idx_ff - CW'(1);
   assign pos_x   = XW'(req.position);
   assign cnt_x   = XW'(cnt_ff);
   assign pos_m1  = pos_x - XW'(1);
   assign full    = (cnt_ff == CW'(DEPTH));
   assign empty   = (cnt_ff == '0);

   always_comb begin
      state_in  = state_ff;
      idx_in    = idx_ff;
      tgt_in    = tgt_ff;
      cnt_in    = cnt_ff;
      val_in    = val_ff;
      status_in = status_ff;
      fpos_in   = fpos_ff;
      data_in   = data_ff;
      wr_en     = 1'b0;
      wr_addr   = idx_ff[AW-1:0];
      wr_data   = rd_data;
      rd_en     = 1'b0;
      rd_addr   = idx_ff[AW-1:0];

      case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               val_in    = req.value;
               status_in = pat_pkg::ST_OK;
               fpos_in   = '0;
               data_in   = '0;
               state_in  = S_DONE;
               case (req.command)
                  pat_pkg::CMD_CLEAR: begin
                     cnt_in = '0;
                  end
                  pat_pkg::CMD_APPEND: begin
                     if (full) begin
                        status_in = pat_pkg::ST_FULL;
                     end else begin
                        wr_en   = 1'b1;
                        wr_addr = cnt_ff[AW-1:0];
                        wr_data = req.value;
                        cnt_in  = cnt_ff + CW'(1);
                     end
                  end
                  pat_pkg::CMD_INSERT: begin
                     if (full) begin
                        status_in = pat_pkg::ST_FULL;
                     end else if (pos_x == '0 || pos_x > cnt_x + XW'(1)) begin
                        status_in = pat_pkg::ST_BADPOS;
                     end else begin
                        idx_in   = cnt_ff;
                        tgt_in   = pos_m1[CW-1:0];
                        state_in = S_UP;
                     end
                  end
                  pat_pkg::CMD_DELETE: begin
                     if (empty) begin
                        status_in = pat_pkg::ST_EMPTY;
                     end else if (pos_x == '0 || pos_x > cnt_x) begin
                        status_in = pat_pkg::ST_BADPOS;
                     end else begin
                        idx_in   = pos_m1[CW-1:0];
                        state_in = S_DN;
                     end
                  end
                  pat_pkg::CMD_SEARCH: begin
                     if (empty) begin
                        status_in = pat_pkg::ST_EMPTY;
                     end else begin
                        idx_in   = '0;
                        state_in = S_SRCH;
                     end
                  end
                  pat_pkg::CMD_READ: begin
                     if (empty) begin
                        status_in = pat_pkg::ST_EMPTY;
                     end else if (pos_x == '0 || pos_x > cnt_x) begin
                        status_in = pat_pkg::ST_BADPOS;
                     end else begin
                        rd_en    = 1'b1;
                        rd_addr  = pos_m1[AW-1:0];
                        state_in = S_RD_WAIT;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         S_UP: begin
            if (idx_ff == tgt_ff) begin
               wr_en    = 1'b1;
               wr_data  = val_ff;
               cnt_in   = cnt_ff + CW'(1);
               state_in = S_DONE;
            end else begin
               rd_en    = 1'b1;
               rd_addr  = idx_dec[AW-1:0];
               state_in = S_UP_WR;
            end
         end
         S_UP_WR: begin
            wr_en    = 1'b1;
            idx_in   = idx_dec;
            state_in = S_UP;
         end
         S_DN: begin
            if (idx_inc >= cnt_ff) begin
               cnt_in   = cnt_ff - CW'(1);
               state_in = S_DONE;
            end else begin
               rd_en    = 1'b1;
               rd_addr  = idx_inc[AW-1:0];
               state_in = S_DN_WR;
            end
         end
         S_DN_WR: begin
            wr_en    = 1'b1;
            idx_in   = idx_inc;
            state_in = S_DN;
         end
         S_SRCH: begin
            if (idx_ff == cnt_ff) begin
               status_in = pat_pkg::ST_NOTFOUND;
               state_in  = S_DONE;
            end else begin
               rd_en    = 1'b1;
               state_in = S_SCMP;
            end
         end
         S_SCMP: begin
            if (rd_data == val_ff) begin
               fpos_in  = 7'(idx_inc);
               state_in = S_DONE;
            end else begin
               idx_in   = idx_inc;
               state_in = S_SRCH;
            end
         end
         S_RD_WAIT: begin
            data_in  = rd_data;
            state_in = S_DONE;
         end
         S_DONE: begin
            if (res_take) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
      idx_ff    <= idx_in;
      tgt_ff    <= tgt_in;
      val_ff    <= val_in;
      status_ff <= status_in;
      fpos_ff   <= fpos_in;
      data_ff   <= data_in;
   end

   assign ready     = (state_ff == S_IDLE);
   assign res_valid = (state_ff == S_DONE);
   assign res       = '{status: status_ff, found_position: fpos_ff,
                        data: data_ff, count: 7'(cnt_ff)};

endmodule
